@@ design/srht_pkg.sv @@
// Shared types and codes for the search result hash table.
package srht_pkg;

  localparam logic [1:0] ACT_STORE    = 2'd0;
  localparam logic [1:0] ACT_RETRIEVE = 2'd1;
  localparam logic [1:0] ACT_CLEAR    = 2'd2;

  localparam logic [2:0] STAT_STORED    = 3'd0;
  localparam logic [2:0] STAT_NO_TABLE  = 3'd1;
  localparam logic [2:0] STAT_FOUND     = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_CLEARED   = 3'd4;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_EMPTY = 2'd3;

  localparam logic [1:0] CFG_TABLE_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_INDEX_BITS     = 2'd1;
  localparam logic [1:0] CFG_MATE_MAGNITUDE = 2'd2;
  localparam logic [1:0] CFG_MATE_WINDOW    = 2'd3;

  localparam logic [4:0] MIN_INDEX_BITS = 5'd4;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_REPLY = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  ply;
    logic [1:0]  bound;
    logic [5:0]  depth;
    logic [15:0] score;
    logic [15:0] move;
    logic [63:0] sig_high;
    logic [63:0] sig_low;
  } entry_t;

endpackage

@@ design/srht_front.sv @@
// Request classifier: slot index selection and command decode.
module srht_front #(
  parameter int MAX_INDEX_BITS = 16
) (
  input  logic [1:0]                action,
  input  logic [63:0]               sig_low,
  input  logic [63:0]               sig_high,
  input  logic [15:0]               move_in,
  input  logic [15:0]               score_in,
  input  logic [5:0]                depth_in,
  input  logic [1:0]                bound_in,
  input  logic [7:0]                ply,
  input  logic                      search_aborted,
  input  logic                      table_enable,
  input  logic [4:0]                index_bits,
  output logic [MAX_INDEX_BITS-1:0] idx,
  output srht_pkg::entry_t          entry
);

  localparam logic [5:0] MAXB = 6'(MAX_INDEX_BITS);

  logic [5:0]      ib;
  srht_pkg::cmd_t  cmd;

  always_comb begin
    priority if (index_bits < srht_pkg::MIN_INDEX_BITS) begin
      ib = {1'b0, srht_pkg::MIN_INDEX_BITS};
    end else if ({1'b0, index_bits} > MAXB) begin
      ib = MAXB;
    end else begin
      ib = {1'b0, index_bits};
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      idx[i] = sig_low[i] & (6'(i) < ib);
    end
  end

  always_comb begin
    unique case (action)
      srht_pkg::ACT_STORE: begin
        if (!table_enable || search_aborted) begin
          cmd = '{op: srht_pkg::OP_REPLY, status: srht_pkg::STAT_NO_TABLE};
        end else begin
          cmd = '{op: srht_pkg::OP_STORE, status: srht_pkg::STAT_STORED};
        end
      end
      srht_pkg::ACT_RETRIEVE: begin
        if (!table_enable) begin
          cmd = '{op: srht_pkg::OP_REPLY, status: srht_pkg::STAT_NO_TABLE};
        end else begin
          cmd = '{op: srht_pkg::OP_READ, status: srht_pkg::STAT_NOT_FOUND};
        end
      end
      srht_pkg::ACT_CLEAR: begin
        if (!table_enable) begin
          cmd = '{op: srht_pkg::OP_REPLY, status: srht_pkg::STAT_CLEARED};
        end else begin
          cmd = '{op: srht_pkg::OP_CLEAR, status: srht_pkg::STAT_CLEARED};
        end
      end
      default: begin
        cmd = '{op: srht_pkg::OP_REPLY, status: srht_pkg::STAT_NO_TABLE};
      end
    endcase
  end

  assign entry = '{cmd: cmd, ply: ply, bound: bound_in, depth: depth_in, score: score_in,
                   move: move_in, sig_high: sig_high, sig_low: sig_low};

endmodule

@@ design/srht_fifo.sv @@
// Two-entry request queue between classifier and executor.
module srht_fifo #(
  parameter int W = 197
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty
);

  logic [W-1:0] data [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = count[1];
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = data[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      data[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/srht_back.sv @@
// Request executor: slot memory, mate score correction, clear sweep and result register.
module srht_back #(
  parameter int MAX_INDEX_BITS = 16,
  parameter int SCORE_BITS     = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [MAX_INDEX_BITS-1:0] head_idx,
  input  srht_pkg::entry_t          head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      init_busy,
  input  logic [14:0]               mate_magnitude,
  input  logic [14:0]               mate_window,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_status,
  output logic [15:0]               out_move,
  output logic [15:0]               out_score,
  output logic [6:0]                out_depth,
  output logic [1:0]                out_bound
);

  localparam int SLOTS = 1 << MAX_INDEX_BITS;
  localparam int CW    = ((SCORE_BITS > 17) ? SCORE_BITS : 17) + 2;
  localparam int MW    = 128 + 16 + SCORE_BITS + 8;
  localparam int O_MV  = 128;
  localparam int O_SC  = 144;
  localparam int O_DB  = 144 + SCORE_BITS;

  localparam logic signed [CW-1:0] SC_HI = {{(CW-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [CW-1:0] SC_LO = ~SC_HI;

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW-1:0] v);
    if (v > SC_HI) begin
      sat = SC_HI;
    end else if (v < SC_LO) begin
      sat = SC_LO;
    end else begin
      sat = v;
    end
  endfunction

  logic [MW-1:0]             mem [SLOTS];
  logic [MW-1:0]             rd_q;
  state_t                    state;
  state_t                    state_next;
  logic [MAX_INDEX_BITS:0]   clr_cnt;
  logic                      mem_we;
  logic [MAX_INDEX_BITS-1:0] mem_waddr;
  logic [MW-1:0]             mem_wdata;
  logic                      rd_en;
  logic                      out_free;
  logic                      ld_out;
  logic                      ld_hit;
  logic [2:0]                ld_status;
  logic [63:0]               cur_sig_low;
  logic [63:0]               cur_sig_high;
  logic [7:0]                cur_ply;

  logic signed [CW-1:0]      thr;
  logic signed [CW-1:0]      nthr;
  logic signed [CW-1:0]      st_ply;
  logic signed [CW-1:0]      st_sc;
  logic signed [CW-1:0]      st_adj;
  logic signed [CW-1:0]      rd_ply;
  logic signed [CW-1:0]      rd_sc;
  logic signed [CW-1:0]      rd_adj;
  logic [7:0]                rd_db;
  logic                      hit;

  assign thr  = $signed({{(CW-15){1'b0}}, mate_magnitude}) -
                $signed({{(CW-15){1'b0}}, mate_window});
  assign nthr = -thr;

  assign st_ply = $signed({{(CW-8){1'b0}}, head.ply});
  assign st_sc  = sat($signed({{(CW-16){head.score[15]}}, head.score}));

  always_comb begin
    st_adj = st_sc;
    if (head.bound == srht_pkg::BOUND_EXACT && (st_sc > thr || st_sc < nthr)) begin
      if (st_sc > $signed(CW'(0))) begin
        st_adj = sat(st_sc + st_ply);
      end else begin
        st_adj = sat(st_sc - st_ply);
      end
    end
  end

  assign rd_ply = $signed({{(CW-8){1'b0}}, cur_ply});
  assign rd_sc  = $signed({{(CW-SCORE_BITS){rd_q[O_DB-1]}}, rd_q[O_DB-1:O_SC]});
  assign rd_db  = rd_q[O_DB+7:O_DB];
  assign hit    = (rd_q[63:0] == cur_sig_low) && (rd_q[127:64] == cur_sig_high);

  always_comb begin
    rd_adj = rd_sc;
    if (rd_db[7:6] == srht_pkg::BOUND_EXACT) begin
      priority if (rd_sc > thr) begin
        rd_adj = sat(rd_sc - rd_ply);
      end else if (rd_sc < nthr) begin
        rd_adj = sat(rd_sc + rd_ply);
      end
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign init_busy = (state == S_INIT);

  always_comb begin
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt[MAX_INDEX_BITS-1:0];
    mem_wdata  = '0;
    rd_en      = 1'b0;
    ld_out     = 1'b0;
    ld_hit     = 1'b0;
    ld_status  = srht_pkg::STAT_NO_TABLE;
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (!clr_cnt[MAX_INDEX_BITS]) begin
          mem_we = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty) begin
          unique case (head.cmd.op)
            srht_pkg::OP_STORE: begin
              if (out_free) begin
                pop       = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = head_idx;
                mem_wdata = {head.bound, head.depth, st_adj[SCORE_BITS-1:0], head.move,
                             head.sig_high, head.sig_low};
                ld_out    = 1'b1;
                ld_status = srht_pkg::STAT_STORED;
              end
            end
            srht_pkg::OP_REPLY: begin
              if (out_free) begin
                pop       = 1'b1;
                ld_out    = 1'b1;
                ld_status = head.cmd.status;
              end
            end
            srht_pkg::OP_READ: begin
              pop        = 1'b1;
              rd_en      = 1'b1;
              state_next = S_READ;
            end
            srht_pkg::OP_CLEAR: begin
              pop        = 1'b1;
              state_next = S_CLEAR;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          ld_out     = 1'b1;
          ld_hit     = hit;
          ld_status  = hit ? srht_pkg::STAT_FOUND : srht_pkg::STAT_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (!clr_cnt[MAX_INDEX_BITS]) begin
          mem_we = 1'b1;
        end else if (out_free) begin
          ld_out     = 1'b1;
          ld_status  = srht_pkg::STAT_CLEARED;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q         <= mem[head_idx];
      cur_sig_low  <= head.sig_low;
      cur_sig_high <= head.sig_high;
      cur_ply      <= head.ply;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (pop && head.cmd.op == srht_pkg::OP_CLEAR) begin
        clr_cnt <= '0;
      end else if (mem_we && (state == S_INIT || state == S_CLEAR)) begin
        clr_cnt <= clr_cnt + (MAX_INDEX_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_status <= ld_status;
      if (ld_hit) begin
        out_move  <= rd_q[O_SC-1:O_MV];
        out_score <= rd_adj[15:0];
        out_depth <= {1'b0, rd_db[5:0]};
        out_bound <= rd_db[7:6];
      end else begin
        out_move  <= '0;
        out_score <= '0;
        out_depth <= '1;
        out_bound <= srht_pkg::BOUND_EMPTY;
      end
    end
  end

endmodule

@@ design/search_result_hash_table_unit.sv @@
// Top level of the search result hash table: configuration registers and stream ports.
//
// Requests enter on s_axis (tuser = action, tdata = signature, move, score, depth,
// bound, ply, abort flag); one result per request leaves on m_axis (tuser = status,
// tdata = move, score, depth, bound), in request order.
// Configuration is written through cfg_we / cfg_index / cfg_data while no request is
// outstanding; index 0 table enable, 1 index bits, 2 mate magnitude, 3 mate window.
// A classifier decodes each request into a two-entry queue; an executor owns a
// single-port slot memory of 2**MAX_INDEX_BITS entries and a registered result.
// Stores and refused requests load the result register from the queue head;
// retrieves first pass through one registered memory read; a clear zeroes one slot
// per cycle before its result is loaded.
// Stores can complete at one per cycle while m_axis_tready stays high; a retrieve
// holds the executor through the read then compare sequence on the memory port.
// After rst the executor zeroes every slot, one per cycle; s_axis_tready stays low
// until that sweep ends. Configuration returns to its defaults.
// When m_axis_tready is low the result holds, up to two further requests queue, then
// s_axis_tready drops.
module search_result_hash_table_unit #(
  parameter int MAX_INDEX_BITS = 16,
  parameter int SCORE_BITS     = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sig_low[63:0], sig_high[127:64], move_in[143:128], score_in[159:144],
  // depth_in[165:160], bound_in[167:166], ply[175:168], search_aborted[176]
  input  logic [183:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // move_out[15:0], score_out[31:16], depth_out[38:32], bound_out[40:39]
  output logic [47:0]  m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [14:0]  cfg_data
);

  localparam int EW = MAX_INDEX_BITS + $bits(srht_pkg::entry_t);

  logic                      table_enable;
  logic [4:0]                index_bits;
  logic [14:0]               mate_magnitude;
  logic [14:0]               mate_window;

  logic [MAX_INDEX_BITS-1:0] fr_idx;
  srht_pkg::entry_t          fr_entry;
  logic                      q_push;
  logic                      q_full;
  logic                      q_pop;
  logic                      q_empty;
  logic [EW-1:0]             q_head;
  logic                      init_busy;

  logic [2:0]                out_status;
  logic [15:0]               out_move;
  logic [15:0]               out_score;
  logic [6:0]                out_depth;
  logic [1:0]                out_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_enable   <= 1'b1;
      index_bits     <= 5'd16;
      mate_magnitude <= 15'd32000;
      mate_window    <= 15'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srht_pkg::CFG_TABLE_ENABLE:   table_enable   <= cfg_data[0];
        srht_pkg::CFG_INDEX_BITS:     index_bits     <= cfg_data[4:0];
        srht_pkg::CFG_MATE_MAGNITUDE: mate_magnitude <= cfg_data;
        srht_pkg::CFG_MATE_WINDOW:    mate_window    <= cfg_data;
      endcase
    end
  end

  assign s_axis_tready = !init_busy && !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  srht_front #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_front (
    .action         (s_axis_tuser),
    .sig_low        (s_axis_tdata[63:0]),
    .sig_high       (s_axis_tdata[127:64]),
    .move_in        (s_axis_tdata[143:128]),
    .score_in       (s_axis_tdata[159:144]),
    .depth_in       (s_axis_tdata[165:160]),
    .bound_in       (s_axis_tdata[167:166]),
    .ply            (s_axis_tdata[175:168]),
    .search_aborted (s_axis_tdata[176]),
    .table_enable   (table_enable),
    .index_bits     (index_bits),
    .idx            (fr_idx),
    .entry          (fr_entry)
  );

  srht_fifo #(
    .W (EW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({fr_idx, fr_entry}),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  srht_back #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .SCORE_BITS     (SCORE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_idx       (q_head[EW-1:$bits(srht_pkg::entry_t)]),
    .head           (srht_pkg::entry_t'(q_head[$bits(srht_pkg::entry_t)-1:0])),
    .empty          (q_empty),
    .pop            (q_pop),
    .init_busy      (init_busy),
    .mate_magnitude (mate_magnitude),
    .mate_window    (mate_window),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_status     (out_status),
    .out_move       (out_move),
    .out_score      (out_score),
    .out_depth      (out_depth),
    .out_bound      (out_bound)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {7'b0, out_bound, out_depth, out_score, out_move};

endmodule

@@ test/tb_search_result_hash_table_unit.sv @@
`timescale 1ns / 1ps
// Testbench of the search result hash table unit: directed table, then random requests.
module tb_search_result_hash_table_unit;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int TABLE_BITS = 16;
  localparam logic [6:0] NO_DEPTH = 7'h7F;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  localparam logic [63:0] SIG_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIG_A_LO = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] SIG_A_HI = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] SIG_C_LO = 64'h8000_0000_0000_1111;
  localparam logic [63:0] SIG_C_HI = 64'h0000_0000_0000_0001;
  localparam logic [63:0] SIG_D_LO = 64'h5A5A_A5A5_0F0F_2222;
  localparam logic [63:0] SIG_D_HI = 64'h0F1E_2D3C_0000_0000;
  localparam logic [63:0] SIG_F_LO = 64'h0000_0001_0000_3333;
  localparam logic [63:0] SIG_F_HI = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIG_G_LO = 64'hC3C3_3C3C_9999_4444;
  localparam logic [63:0] SIG_G_HI = 64'h0000_0000_0000_0001;
  localparam logic [63:0] SIG_H_LO = 64'h0000_0000_0000_5555;

  typedef enum logic [1:0] {
    ROW_ASK,
    ROW_KNOWN,
    ROW_REG
  } row_kind_t;

  typedef struct {
    logic [1:0]         action;
    logic [63:0]        sig_lo;
    logic [63:0]        sig_hi;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic [5:0]         depth;
    logic [1:0]         bound;
    logic [7:0]         ply;
    logic               aborted;
  } request_t;

  typedef struct {
    logic [2:0]         status;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic [6:0]         depth;
    logic [1:0]         bound;
  } reply_t;

  typedef struct {
    logic [63:0]        sig_lo;
    logic [63:0]        sig_hi;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic [5:0]         depth;
    logic [1:0]         bound;
  } slot_t;

  typedef struct {
    row_kind_t   kind;
    request_t    req;
    reply_t      want;
    logic [1:0]  reg_idx;
    logic [14:0] reg_val;
  } row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [14:0]  cfg_data = '0;

  logic        tbl_enable;
  logic [4:0]  tbl_index_bits;
  logic [14:0] tbl_mate_mag;
  logic [14:0] tbl_mate_win;
  slot_t       slots [int];
  reply_t      replies_due [$];
  logic [127:0] known_sigs [$];

  int cycle_count = 0;
  int error_count = 0;
  int request_count = 0;
  int hit_count = 0;
  int clear_count = 0;
  int clears_left = 3;
  int send_idle_pct = 38;
  int recv_idle_pct = 38;

  search_result_hash_table_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [15:0] clip_score(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int slot_index(logic [63:0] sig);
    int b;
    b = tbl_index_bits;
    if (b < srht_pkg::MIN_INDEX_BITS) b = srht_pkg::MIN_INDEX_BITS;
    if (b > TABLE_BITS) b = TABLE_BITS;
    return int'(sig[TABLE_BITS-1:0]) & ((1 << b) - 1);
  endfunction

  function automatic reply_t empty_reply(logic [2:0] status);
    reply_t r;
    r.status = status;
    r.move = '0;
    r.score = '0;
    r.depth = NO_DEPTH;
    r.bound = srht_pkg::BOUND_EMPTY;
    return r;
  endfunction

  function automatic reply_t table_reply(request_t q);
    reply_t r;
    slot_t s;
    int idx;
    int thr;
    int v;
    idx = slot_index(q.sig_lo);
    thr = int'(tbl_mate_mag) - int'(tbl_mate_win);
    v = q.score;
    case (q.action)
      srht_pkg::ACT_STORE: begin
        if (!tbl_enable || q.aborted) return empty_reply(srht_pkg::STAT_NO_TABLE);
        // hold mate scores as distance from this position
        if (q.bound == srht_pkg::BOUND_EXACT && (v > thr || v < -thr))
          v = (v > 0) ? v + int'(q.ply) : v - int'(q.ply);
        s.sig_lo = q.sig_lo;
        s.sig_hi = q.sig_hi;
        s.move = q.move;
        s.score = clip_score(v);
        s.depth = q.depth;
        s.bound = q.bound;
        slots[idx] = s;
        return empty_reply(srht_pkg::STAT_STORED);
      end
      srht_pkg::ACT_RETRIEVE: begin
        if (!tbl_enable) return empty_reply(srht_pkg::STAT_NO_TABLE);
        if (slots.exists(idx)) begin
          s = slots[idx];
        end else begin
          s.sig_lo = '0;
          s.sig_hi = '0;
          s.move = '0;
          s.score = '0;
          s.depth = '0;
          s.bound = srht_pkg::BOUND_EXACT;
        end
        if (s.sig_lo != q.sig_lo || s.sig_hi != q.sig_hi)
          return empty_reply(srht_pkg::STAT_NOT_FOUND);
        v = s.score;
        if (s.bound == srht_pkg::BOUND_EXACT) begin
          if (v > thr) v = v - int'(q.ply);
          else if (v < -thr) v = v + int'(q.ply);
        end
        r.status = srht_pkg::STAT_FOUND;
        r.move = s.move;
        r.score = clip_score(v);
        r.depth = {1'b0, s.depth};
        r.bound = s.bound;
        return r;
      end
      srht_pkg::ACT_CLEAR: begin
        if (tbl_enable) slots.delete();
        return empty_reply(srht_pkg::STAT_CLEARED);
      end
      default: return empty_reply(srht_pkg::STAT_NO_TABLE);
    endcase
  endfunction

  function automatic request_t rq(logic [1:0] act, logic [63:0] lo, logic [63:0] hi,
                                  logic [15:0] mv, logic signed [15:0] sc, logic [5:0] dp,
                                  logic [1:0] bd, logic [7:0] pl, logic ab);
    request_t q;
    q.action = act;
    q.sig_lo = lo;
    q.sig_hi = hi;
    q.move = mv;
    q.score = sc;
    q.depth = dp;
    q.bound = bd;
    q.ply = pl;
    q.aborted = ab;
    return q;
  endfunction

  function automatic row_t ask(request_t q);
    row_t r;
    r.kind = ROW_ASK;
    r.req = q;
    return r;
  endfunction

  function automatic row_t known(request_t q, reply_t w);
    row_t r;
    r.kind = ROW_KNOWN;
    r.req = q;
    r.want = w;
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, logic [14:0] val);
    row_t r;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic request_t draw_request();
    request_t q;
    logic [127:0] pick;
    int thr;
    int roll;
    int k;
    thr = int'(tbl_mate_mag) - int'(tbl_mate_win);
    q.sig_lo = {$urandom, $urandom};
    q.sig_hi = {$urandom, $urandom};
    q.move = 16'($urandom);
    q.depth = 6'($urandom);
    q.aborted = ($urandom_range(0, 99) < 8);
    q.bound = ($urandom_range(0, 99) < 55) ? srht_pkg::BOUND_EXACT
                                           : 2'($urandom_range(1, 3));
    roll = $urandom_range(0, 9);
    if (roll < 2) q.ply = 8'hFF;
    else if (roll == 2) q.ply = 8'h00;
    else q.ply = 8'($urandom);
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      q.score = 16'($urandom);
    end else if (roll < 7) begin
      // land around the edge of the mate band
      k = ($urandom_range(0, 1) == 1) ? thr : -thr;
      q.score = clip_score(k + int'($urandom_range(0, 600)) - 300);
    end else if (roll == 7) begin
      case ($urandom_range(0, 2))
        0: q.score = 16'sh7FFF;
        1: q.score = 16'sh8000;
        default: q.score = 16'sh8001;
      endcase
    end else begin
      q.score = clip_score(int'($urandom_range(0, 200)) - 100);
    end
    pick = (known_sigs.size() != 0) ? known_sigs[$urandom_range(0, known_sigs.size() - 1)]
                                    : '0;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      q.action = ACT_UNUSED;
    end else if (roll < 4 && clears_left > 0) begin
      q.action = srht_pkg::ACT_CLEAR;
      clears_left--;
    end else if (roll < 50) begin
      q.action = srht_pkg::ACT_STORE;
      if ($urandom_range(0, 99) < 25) {q.sig_hi, q.sig_lo} = pick;
      known_sigs.push_back({q.sig_hi, q.sig_lo});
      if (known_sigs.size() > 32) void'(known_sigs.pop_front());
    end else begin
      q.action = srht_pkg::ACT_RETRIEVE;
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        {q.sig_hi, q.sig_lo} = pick;
      end else if (roll == 7) begin
        {q.sig_hi, q.sig_lo} = pick;
        k = $urandom_range(0, 63);
        q.sig_hi[k] = ~q.sig_hi[k];
      end else if (roll == 8) begin
        // same slot, different signature
        q.sig_lo[15:0] = pick[15:0];
      end else if ($urandom_range(0, 1) == 1) begin
        q.sig_lo = '0;
        q.sig_hi = '0;
      end
    end
    return q;
  endfunction

  task automatic send_request(input request_t q, input logic has_want, input reply_t want);
    reply_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, q.aborted, q.ply, q.bound, q.depth, q.score, q.move,
                     q.sig_hi, q.sig_lo};
    s_axis_tuser <= q.action;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (q.action == srht_pkg::ACT_CLEAR && tbl_enable) clear_count++;
    got = table_reply(q);
    if (got.status == srht_pkg::STAT_FOUND) hit_count++;
    request_count++;
    replies_due.push_back(has_want ? want : got);
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      srht_pkg::CFG_TABLE_ENABLE: tbl_enable = val[0];
      srht_pkg::CFG_INDEX_BITS: tbl_index_bits = val[4:0];
      srht_pkg::CFG_MATE_MAGNITUDE: tbl_mate_mag = val;
      default: tbl_mate_win = val;
    endcase
  endtask

  task automatic apply_setting(input logic en, input logic [4:0] bits,
                               input logic [14:0] mag, input logic [14:0] win);
    drain_replies();
    write_reg(srht_pkg::CFG_TABLE_ENABLE, {14'b0, en});
    write_reg(srht_pkg::CFG_INDEX_BITS, {10'b0, bits});
    write_reg(srht_pkg::CFG_MATE_MAGNITUDE, mag);
    write_reg(srht_pkg::CFG_MATE_WINDOW, win);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_search_result_hash_table_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_reply
    reply_t seen;
    reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.status = m_axis_tuser;
      seen.move = m_axis_tdata[15:0];
      seen.score = m_axis_tdata[31:16];
      seen.depth = m_axis_tdata[38:32];
      seen.bound = m_axis_tdata[40:39];
      if (replies_due.size() == 0) begin
        if (error_count < 10)
          $display("reply with none outstanding: status %0d move %h score %0d",
                   seen.status, seen.move, seen.score);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        if (seen.status !== want.status || seen.move !== want.move ||
            seen.score !== want.score || seen.depth !== want.depth ||
            seen.bound !== want.bound) begin
          if (error_count < 10)
            $display({"reply mismatch: expected st %0d mv %h sc %0d dp %0d bd %0d,",
                      " got st %0d mv %h sc %0d dp %0d bd %0d"},
                     want.status, want.move, want.score, $signed(want.depth), want.bound,
                     seen.status, seen.move, seen.score, $signed(seen.depth), seen.bound);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t plan [$];
    reply_t none;
    int phase;
    int n;
    tbl_enable = 1'b1;
    tbl_index_bits = 5'd16;
    tbl_mate_mag = 15'd32000;
    tbl_mate_win = 15'd1000;
    none = empty_reply(srht_pkg::STAT_NO_TABLE);

    plan.push_back(known(rq(srht_pkg::ACT_RETRIEVE, '0, '0, '0, '0, '0,
                            srht_pkg::BOUND_EXACT, '0, 1'b0),
                         '{srht_pkg::STAT_FOUND, 16'h0, 16'sh0, 7'd0,
                           srht_pkg::BOUND_EXACT}));
    plan.push_back(known(rq(srht_pkg::ACT_RETRIEVE, 64'h5, '0, '0, '0, '0,
                            srht_pkg::BOUND_EXACT, '0, 1'b0),
                         empty_reply(srht_pkg::STAT_NOT_FOUND)));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, SIG_ONES, SIG_ONES, 16'hFFFF, 16'sh7FFF,
                            6'd63, srht_pkg::BOUND_EXACT, 8'hFF, 1'b0),
                         empty_reply(srht_pkg::STAT_STORED)));
    plan.push_back(ask(rq(srht_pkg::ACT_RETRIEVE, SIG_ONES, SIG_ONES, '0, '0, '0,
                          srht_pkg::BOUND_EXACT, 8'd0, 1'b0)));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, SIG_A_LO, SIG_A_HI, 16'h1234, 16'sh8000,
                            6'd0, srht_pkg::BOUND_EXACT, 8'hFF, 1'b0),
                         empty_reply(srht_pkg::STAT_STORED)));
    plan.push_back(ask(rq(srht_pkg::ACT_RETRIEVE, SIG_A_LO, SIG_A_HI, '0, '0, '0,
                          srht_pkg::BOUND_EXACT, 8'd3, 1'b0)));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, SIG_C_LO, SIG_C_HI, 16'h00A5, 16'sd50,
                            6'd5, srht_pkg::BOUND_EXACT, 8'd1, 1'b1),
                         empty_reply(srht_pkg::STAT_NO_TABLE)));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, SIG_C_LO, SIG_C_HI, 16'h5A00, 16'sd31500,
                            6'd12, srht_pkg::BOUND_EMPTY, 8'd10, 1'b0),
                         empty_reply(srht_pkg::STAT_STORED)));
    plan.push_back(ask(rq(srht_pkg::ACT_RETRIEVE, SIG_C_LO, SIG_C_HI, '0, '0, '0,
                          srht_pkg::BOUND_EXACT, 8'd20, 1'b0)));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, SIG_D_LO, SIG_D_HI, 16'h0001, 16'sd31999,
                            6'd33, BOUND_UPPER, 8'd9, 1'b0),
                         empty_reply(srht_pkg::STAT_STORED)));
    plan.push_back(known(rq(srht_pkg::ACT_RETRIEVE, SIG_D_LO, ~SIG_D_HI, '0, '0, '0,
                            srht_pkg::BOUND_EXACT, 8'd9, 1'b0),
                         empty_reply(srht_pkg::STAT_NOT_FOUND)));
    plan.push_back(ask(rq(srht_pkg::ACT_RETRIEVE, SIG_D_LO, SIG_D_HI, '0, '0, '0,
                          BOUND_LOWER, 8'd9, 1'b0)));
    plan.push_back(known(rq(ACT_UNUSED, SIG_D_LO, SIG_D_HI, '1, '1, '1,
                            srht_pkg::BOUND_EMPTY, '1, 1'b1),
                         empty_reply(srht_pkg::STAT_NO_TABLE)));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, SIG_F_LO, SIG_F_HI, 16'h8001, 16'sd31001,
                            6'd7, srht_pkg::BOUND_EXACT, 8'd7, 1'b0),
                         empty_reply(srht_pkg::STAT_STORED)));
    plan.push_back(ask(rq(srht_pkg::ACT_RETRIEVE, SIG_F_LO, SIG_F_HI, '0, '0, '0,
                          srht_pkg::BOUND_EXACT, 8'd2, 1'b0)));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, SIG_G_LO, SIG_G_HI, 16'h4000, -16'sd31000,
                            6'd1, srht_pkg::BOUND_EXACT, 8'd7, 1'b0),
                         empty_reply(srht_pkg::STAT_STORED)));
    plan.push_back(ask(rq(srht_pkg::ACT_RETRIEVE, SIG_G_LO, SIG_G_HI, '0, '0, '0,
                          srht_pkg::BOUND_EXACT, 8'd200, 1'b0)));
    plan.push_back(known(rq(srht_pkg::ACT_RETRIEVE, SIG_F_LO ^ 64'h1_0000, SIG_F_HI,
                            '0, '0, '0, srht_pkg::BOUND_EXACT, 8'd0, 1'b0),
                         empty_reply(srht_pkg::STAT_NOT_FOUND)));
    plan.push_back(reg_row(srht_pkg::CFG_TABLE_ENABLE, 15'd0));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, SIG_H_LO, SIG_H_LO, 16'h0101, 16'sd5,
                            6'd2, srht_pkg::BOUND_EXACT, 8'd0, 1'b0),
                         empty_reply(srht_pkg::STAT_NO_TABLE)));
    plan.push_back(known(rq(srht_pkg::ACT_RETRIEVE, SIG_F_LO, SIG_F_HI, '0, '0, '0,
                            srht_pkg::BOUND_EXACT, 8'd0, 1'b0),
                         empty_reply(srht_pkg::STAT_NO_TABLE)));
    plan.push_back(known(rq(srht_pkg::ACT_CLEAR, '0, '0, '0, '0, '0,
                            srht_pkg::BOUND_EXACT, '0, 1'b0),
                         empty_reply(srht_pkg::STAT_CLEARED)));
    plan.push_back(reg_row(srht_pkg::CFG_TABLE_ENABLE, 15'd1));
    plan.push_back(ask(rq(srht_pkg::ACT_RETRIEVE, SIG_F_LO, SIG_F_HI, '0, '0, '0,
                          srht_pkg::BOUND_EXACT, 8'd0, 1'b0)));
    plan.push_back(known(rq(srht_pkg::ACT_CLEAR, '0, '0, '0, '0, '0,
                            srht_pkg::BOUND_EXACT, '0, 1'b0),
                         empty_reply(srht_pkg::STAT_CLEARED)));
    plan.push_back(known(rq(srht_pkg::ACT_RETRIEVE, SIG_F_LO, SIG_F_HI, '0, '0, '0,
                            srht_pkg::BOUND_EXACT, 8'd0, 1'b0),
                         empty_reply(srht_pkg::STAT_NOT_FOUND)));
    plan.push_back(reg_row(srht_pkg::CFG_INDEX_BITS, 15'd2));
    plan.push_back(reg_row(srht_pkg::CFG_MATE_MAGNITUDE, 15'd0));
    plan.push_back(reg_row(srht_pkg::CFG_MATE_WINDOW, 15'h7FFF));
    plan.push_back(known(rq(srht_pkg::ACT_STORE, 64'hFFFF_FFF3, 64'h1234, 16'h0F0F, 16'sd0,
                            6'd9, srht_pkg::BOUND_EXACT, 8'd5, 1'b0),
                         empty_reply(srht_pkg::STAT_STORED)));
    plan.push_back(known(rq(srht_pkg::ACT_RETRIEVE, 64'h3, 64'h1234, '0, '0, '0,
                            srht_pkg::BOUND_EXACT, 8'd5, 1'b0),
                         empty_reply(srht_pkg::STAT_NOT_FOUND)));
    plan.push_back(ask(rq(srht_pkg::ACT_RETRIEVE, 64'hFFFF_FFF3, 64'h1234, '0, '0, '0,
                          srht_pkg::BOUND_EXACT, 8'd5, 1'b0)));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REG: begin
          drain_replies();
          write_reg(plan[i].reg_idx, plan[i].reg_val);
        end
        ROW_KNOWN: send_request(plan[i].req, 1'b1, plan[i].want);
        default: send_request(plan[i].req, 1'b0, none);
      endcase
    end

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_setting(1'b1, 5'd16, 15'd32000, 15'd1000);
        1: apply_setting(1'b1, 5'd4, 15'h7FFF, 15'd0);
        2: apply_setting(1'b1, 5'd0, 15'd0, 15'h7FFF);
        3: apply_setting(1'b0, 5'd16, 15'd32000, 15'd1000);
        4: apply_setting(1'b1, 5'd31, 15'($urandom), 15'($urandom));
        default: apply_setting(1'b1, 5'($urandom_range(5, 15)), 15'h7FFF, 15'h7FFF);
      endcase
      // run one phase flat out on both sides
      send_idle_pct = (phase == 1) ? 0 : 38;
      recv_idle_pct = (phase == 1) ? 0 : 38;
      n = (phase == 3) ? 40 : 102;
      for (int k = 0; k < n; k++) begin
        if (phase == 0 && k == 50) drain_replies();
        send_request(draw_request(), 1'b0, none);
      end
    end

    drain_replies();
    repeat (20) @(posedge clk);
    $display("covered %0d requests with %0d table hits and %0d full clears",
             request_count, hit_count, clear_count);
    $display({"register settings swept: table off, index width 4 to 16 and beyond,",
              " mate band extremes"});
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("tb_search_result_hash_table_unit: done, clean");
    end else begin
      $display("tb_search_result_hash_table_unit: done, errors");
    end
    $finish;
  end

endmodule
